FILE: hdl/avw_pkg.sv
// ----------------------------------------------------------------------------
// avw_pkg
// Shared constants, types and the quarter-wave sine table for the voice.
// ----------------------------------------------------------------------------
package avw_pkg;

  localparam int PHASE_BITS   = 24;
  localparam int LEVEL_BITS   = 16;
  localparam int TIMER_BITS   = 20;
  localparam int SINE_DEPTH   = 256;
  localparam int SINE_ABITS   = $clog2(SINE_DEPTH);

  localparam int CFG_W        = 16;
  localparam int CFG_IDX_W    = 3;
  localparam int PHASE_STEP_W = 24;
  localparam int DURATION_W   = 20;
  localparam int WAVE_SEL_W   = 3;
  localparam int STAGE_W      = 3;
  localparam int SAMPLE_W     = 16;
  localparam int IN_TDATA_W   = 48;
  localparam int OUT_TDATA_W  = 24;

  localparam logic [LEVEL_BITS-1:0] LEVEL_MAX = '1;
  localparam logic [TIMER_BITS-1:0] TIMER_MAX = '1;

  localparam logic [15:0] LFSR_SEED = 16'hACE1;
  localparam logic [15:0] LFSR_TAPS = 16'hB400;

  localparam logic [CFG_W-1:0] ATTACK_STEP_RST   = 16'd1024;
  localparam logic [CFG_W-1:0] DECAY_STEP_RST    = 16'd256;
  localparam logic [CFG_W-1:0] SUSTAIN_LEVEL_RST = 16'd49152;
  localparam logic [CFG_W-1:0] RELEASE_STEP_RST  = 16'd256;
  localparam logic [CFG_W-1:0] OUTPUT_GAIN_RST   = 16'd65535;

  // divisor of the gain and level scaling: 65535 * (2^16 - 1)
  localparam logic [32:0] DIV_D  = 33'd4294836225;
  localparam logic [32:0] DIV_2D = 33'd8589672450;

  localparam logic [WAVE_SEL_W-1:0] WAVE_SQUARE   = 3'd0;
  localparam logic [WAVE_SEL_W-1:0] WAVE_SINE     = 3'd1;
  localparam logic [WAVE_SEL_W-1:0] WAVE_TRIANGLE = 3'd2;
  localparam logic [WAVE_SEL_W-1:0] WAVE_SAW      = 3'd3;
  localparam logic [WAVE_SEL_W-1:0] WAVE_NOISE    = 3'd4;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ATTACK_STEP   = 3'd0,
    REG_DECAY_STEP    = 3'd1,
    REG_SUSTAIN_LEVEL = 3'd2,
    REG_RELEASE_STEP  = 3'd3,
    REG_OUTPUT_GAIN   = 3'd4
  } cfg_reg_t;

  typedef enum logic [STAGE_W-1:0] {
    ST_IDLE    = 3'd0,
    ST_ATTACK  = 3'd1,
    ST_DECAY   = 3'd2,
    ST_SUSTAIN = 3'd3,
    ST_RELEASE = 3'd4
  } env_stage_t;

  typedef struct packed {
    logic load_note;
    logic phase_adv;
    logic wave_env;
    logic mul1;
    logic mul2;
    logic div;
    logic out_load;
    logic out_zero;
  } avw_cmd_t;

  typedef struct packed {
    logic active;
  } avw_status_t;

  localparam logic [14:0] SINE_PEAK = 15'd32767;

  typedef logic [14:0] sine_rom_t [SINE_DEPTH];

  // 32767 * sin(pi/2 * i / SINE_DEPTH) by an odd polynomial in Q16
  function automatic sine_rom_t build_sine_rom();
    sine_rom_t   rom;
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] t;
    logic [63:0] y;
    for (int i = 0; i < SINE_DEPTH; i++) begin
      x  = (64'(i) << 16) / SINE_DEPTH;
      x2 = (x * x) >> 16;
      t  = (64'd5223 * x2) >> 16;
      t  = 64'd42334 - t;
      t  = (t * x2) >> 16;
      t  = 64'd102944 - t;
      y  = (t * x) >> 16;
      y  = (y * 64'd32767 + 64'd32768) >> 16;
      if (y > 64'd32767) begin
        y = 64'd32767;
      end
      rom[i] = 15'(y);
    end
    return rom;
  endfunction

  localparam sine_rom_t SINE_ROM = build_sine_rom();

endpackage

FILE: hdl/avw_ctrl.sv
// ----------------------------------------------------------------------------
// avw_ctrl
// Sequencer for the voice: takes transactions, steps the datapath through
// wave/envelope, two multiplies and the scaling divide, and owns out_tvalid.
// ----------------------------------------------------------------------------
module avw_ctrl (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic                  in_is_note,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  input  avw_pkg::avw_status_t  status,
  output avw_pkg::avw_cmd_t     cmd
);
  import avw_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE = 3'd0,
    S_WAVE = 3'd1,
    S_MUL1 = 3'd2,
    S_MUL2 = 3'd3,
    S_DIV  = 3'd4,
    S_OUT  = 3'd5
  } state_t;

  state_t state_r;
  state_t state_nxt;
  logic   zero_r;
  logic   zero_nxt;
  logic   out_valid_r;
  logic   out_valid_nxt;
  logic   accept;
  logic   out_free;

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;
  assign accept     = in_tvalid && in_tready;
  assign out_free   = !out_valid_r || out_tready;

  always_comb begin
    cmd           = '0;
    state_nxt     = state_r;
    zero_nxt      = zero_r;
    out_valid_nxt = out_valid_r && !out_tready;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          if (in_is_note) begin
            cmd.load_note = 1'b1;
          end else if (status.active) begin
            cmd.phase_adv = 1'b1;
            zero_nxt      = 1'b0;
            state_nxt     = S_WAVE;
          end else begin
            zero_nxt  = 1'b1;
            state_nxt = S_OUT;
          end
        end
      end
      S_WAVE: begin
        cmd.wave_env = 1'b1;
        state_nxt    = S_MUL1;
      end
      S_MUL1: begin
        cmd.mul1  = 1'b1;
        state_nxt = S_MUL2;
      end
      S_MUL2: begin
        cmd.mul2  = 1'b1;
        state_nxt = S_DIV;
      end
      S_DIV: begin
        cmd.div   = 1'b1;
        state_nxt = S_OUT;
      end
      S_OUT: begin
        if (out_free) begin
          cmd.out_load  = 1'b1;
          cmd.out_zero  = zero_r;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      zero_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      zero_r      <= zero_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

FILE: hdl/avw_datapath.sv
// ----------------------------------------------------------------------------
// avw_datapath
// Voice state, configuration registers, oscillator, ADSR envelope and the
// gain/level scaling with a reciprocal-style divide and output register.
// ----------------------------------------------------------------------------
module avw_datapath (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 cfg_we,
  input  logic [avw_pkg::CFG_IDX_W-1:0]        cfg_addr,
  input  logic [avw_pkg::CFG_W-1:0]            cfg_wdata,
  input  logic [avw_pkg::PHASE_STEP_W-1:0]     note_phase_step,
  input  logic [avw_pkg::WAVE_SEL_W-1:0]       note_waveform,
  input  logic [avw_pkg::DURATION_W-1:0]       note_duration,
  input  avw_pkg::avw_cmd_t                    cmd,
  output avw_pkg::avw_status_t                 status,
  output logic signed [avw_pkg::SAMPLE_W-1:0]  res_sample,
  output logic                                 res_voice_active,
  output logic [avw_pkg::STAGE_W-1:0]          res_stage
);
  import avw_pkg::*;

  // configuration
  logic [CFG_W-1:0] attack_r;
  logic [CFG_W-1:0] decay_r;
  logic [CFG_W-1:0] sustain_r;
  logic [CFG_W-1:0] release_r;
  logic [CFG_W-1:0] gain_r;

  // voice state
  logic [PHASE_BITS-1:0] phase_acc_r;
  logic [PHASE_BITS-1:0] phase_acc_nxt;
  logic [PHASE_BITS-1:0] phase_incr_r;
  logic [PHASE_BITS-1:0] phase_incr_nxt;
  logic [WAVE_SEL_W-1:0] wave_sel_r;
  logic [WAVE_SEL_W-1:0] wave_sel_nxt;
  logic [LEVEL_BITS-1:0] env_level_r;
  logic [LEVEL_BITS-1:0] env_level_nxt;
  env_stage_t            env_stage_r;
  env_stage_t            env_stage_nxt;
  logic [TIMER_BITS-1:0] tick_timer_r;
  logic [TIMER_BITS-1:0] tick_timer_nxt;
  logic [TIMER_BITS-1:0] note_length_r;
  logic [TIMER_BITS-1:0] note_length_nxt;
  logic [15:0]           lfsr_r;
  logic [15:0]           lfsr_nxt;

  // arithmetic pipeline
  logic signed [16:0]    w_r;
  logic                  neg_r;
  logic [31:0]           p1_r;
  logic [31:0]           p1_nxt;
  logic [47:0]           p2_r;
  logic [47:0]           p2_nxt;
  logic [15:0]           q0_r;
  logic [32:0]           rem_r;
  logic [32:0]           rem_nxt;
  logic signed [SAMPLE_W-1:0] sample_nxt;

  // wave forming
  logic [15:0]           u;
  logic [1:0]            quad;
  logic [SINE_ABITS-1:0] sin_raw;
  logic [SINE_ABITS-1:0] sin_idx;
  logic [14:0]           sin_mag;
  logic [15:0]           lfsr_adv;
  logic signed [17:0]    tri_val;
  logic signed [16:0]    wave_val;

  // envelope
  logic [LEVEL_BITS:0]   lvl_sum;
  logic [LEVEL_BITS:0]   dec_floor;
  logic [LEVEL_BITS-1:0] lvl_env;
  env_stage_t            stage_env;
  logic [TIMER_BITS-1:0] timer_inc;

  // scaling
  logic [16:0]           w_abs;
  logic [1:0]            corr;
  logic [16:0]           mag;

  assign status.active = (env_stage_r != ST_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      attack_r  <= ATTACK_STEP_RST;
      decay_r   <= DECAY_STEP_RST;
      sustain_r <= SUSTAIN_LEVEL_RST;
      release_r <= RELEASE_STEP_RST;
      gain_r    <= OUTPUT_GAIN_RST;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        REG_ATTACK_STEP:   attack_r  <= cfg_wdata;
        REG_DECAY_STEP:    decay_r   <= cfg_wdata;
        REG_SUSTAIN_LEVEL: sustain_r <= cfg_wdata;
        REG_RELEASE_STEP:  release_r <= cfg_wdata;
        REG_OUTPUT_GAIN:   gain_r    <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  assign u        = 16'({phase_acc_r, 16'b0} >> PHASE_BITS);
  assign quad     = u[15:14];
  assign sin_raw  = u[13 -: SINE_ABITS];
  assign sin_idx  = quad[0] ? SINE_ABITS'(~sin_raw + 1'b1) : sin_raw;
  assign sin_mag  = (quad[0] && sin_raw == '0) ? SINE_PEAK : SINE_ROM[sin_idx];
  assign lfsr_adv = {1'b0, lfsr_r[15:1]} ^ (lfsr_r[0] ? LFSR_TAPS : 16'h0000);

  always_comb begin
    tri_val  = '0;
    wave_val = '0;
    case (wave_sel_r)
      WAVE_SQUARE: begin
        wave_val = u[15] ? -17'sd32767 : 17'sd32767;
      end
      WAVE_SINE: begin
        wave_val = quad[1] ? -$signed({2'b00, sin_mag}) : $signed({2'b00, sin_mag});
      end
      WAVE_TRIANGLE: begin
        if (!u[15]) begin
          wave_val = $signed({1'b0, u[14:0], 1'b0}) - 17'sd32768;
        end else begin
          tri_val  = 18'sd98304 - $signed({1'b0, u, 1'b0});
          wave_val = (tri_val > 18'sd32767) ? 17'sd32767 : 17'(tri_val);
        end
      end
      WAVE_SAW: begin
        wave_val = 17'($signed({~u[15], u[14:0]}));
      end
      WAVE_NOISE: begin
        wave_val = 17'($signed({~lfsr_adv[15], lfsr_adv[14:0]}));
      end
      default: begin
        wave_val = '0;
      end
    endcase
  end

  always_comb begin
    lvl_sum   = {1'b0, env_level_r} + {1'b0, attack_r};
    dec_floor = {1'b0, sustain_r} + {1'b0, decay_r};
    lvl_env   = env_level_r;
    stage_env = env_stage_r;
    unique case (env_stage_r)
      ST_ATTACK: begin
        if (lvl_sum >= {1'b0, LEVEL_MAX}) begin
          lvl_env   = LEVEL_MAX;
          stage_env = ST_DECAY;
        end else begin
          lvl_env = lvl_sum[LEVEL_BITS-1:0];
        end
      end
      ST_DECAY: begin
        if ({1'b0, env_level_r} <= dec_floor) begin
          lvl_env   = sustain_r;
          stage_env = ST_SUSTAIN;
        end else begin
          lvl_env = env_level_r - decay_r;
        end
      end
      ST_RELEASE: begin
        if (env_level_r <= release_r) begin
          lvl_env   = '0;
          stage_env = ST_IDLE;
        end else begin
          lvl_env = env_level_r - release_r;
        end
      end
      default: begin
      end
    endcase
    timer_inc = (tick_timer_r != TIMER_MAX) ? tick_timer_r + 1'b1 : tick_timer_r;
  end

  always_comb begin
    phase_acc_nxt   = phase_acc_r;
    phase_incr_nxt  = phase_incr_r;
    wave_sel_nxt    = wave_sel_r;
    env_level_nxt   = env_level_r;
    env_stage_nxt   = env_stage_r;
    tick_timer_nxt  = tick_timer_r;
    note_length_nxt = note_length_r;
    lfsr_nxt        = lfsr_r;
    if (cmd.load_note) begin
      phase_incr_nxt  = PHASE_BITS'(note_phase_step);
      wave_sel_nxt    = note_waveform;
      note_length_nxt = TIMER_BITS'(note_duration);
      phase_acc_nxt   = '0;
      tick_timer_nxt  = '0;
      env_level_nxt   = '0;
      env_stage_nxt   = ST_ATTACK;
    end
    if (cmd.phase_adv) begin
      phase_acc_nxt = phase_acc_r + phase_incr_r;
    end
    if (cmd.wave_env) begin
      env_level_nxt  = lvl_env;
      tick_timer_nxt = timer_inc;
      env_stage_nxt  = stage_env;
      if (timer_inc >= note_length_r &&
          (stage_env == ST_ATTACK || stage_env == ST_DECAY || stage_env == ST_SUSTAIN)) begin
        env_stage_nxt = ST_RELEASE;
      end
      if (wave_sel_r == WAVE_NOISE) begin
        lfsr_nxt = lfsr_adv;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_acc_r   <= '0;
      phase_incr_r  <= '0;
      wave_sel_r    <= '0;
      env_level_r   <= '0;
      env_stage_r   <= ST_IDLE;
      tick_timer_r  <= '0;
      note_length_r <= '0;
      lfsr_r        <= LFSR_SEED;
    end else begin
      phase_acc_r   <= phase_acc_nxt;
      phase_incr_r  <= phase_incr_nxt;
      wave_sel_r    <= wave_sel_nxt;
      env_level_r   <= env_level_nxt;
      env_stage_r   <= env_stage_nxt;
      tick_timer_r  <= tick_timer_nxt;
      note_length_r <= note_length_nxt;
      lfsr_r        <= lfsr_nxt;
    end
  end

  // floor(p2 / DIV_D): estimate from the top bits, then at most two corrections
  always_comb begin
    w_abs   = w_r[16] ? 17'(-w_r) : 17'(w_r);
    p1_nxt  = w_abs[15:0] * gain_r;
    p2_nxt  = p1_r * env_level_r;
    rem_nxt = {1'b0, p2_r[31:0]} + ({p2_r[47:32], 17'b0} - 33'(p2_r[47:32]));
    if (rem_r >= DIV_2D) begin
      corr = 2'd2;
    end else if (rem_r >= DIV_D) begin
      corr = 2'd1;
    end else begin
      corr = 2'd0;
    end
    mag = {1'b0, q0_r} + 17'(corr);
    if (mag > 17'd32768) begin
      mag = 17'd32768;
    end
    if (cmd.out_zero) begin
      sample_nxt = '0;
    end else if (neg_r) begin
      sample_nxt = SAMPLE_W'(-$signed(mag));
    end else if (mag > 17'd32767) begin
      sample_nxt = 16'sd32767;
    end else begin
      sample_nxt = SAMPLE_W'(mag);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.wave_env) begin
      w_r <= wave_val;
    end
    if (cmd.mul1) begin
      p1_r  <= p1_nxt;
      neg_r <= w_r[16];
    end
    if (cmd.mul2) begin
      p2_r <= p2_nxt;
    end
    if (cmd.div) begin
      q0_r  <= p2_r[47:32];
      rem_r <= rem_nxt;
    end
    if (cmd.out_load) begin
      res_sample       <= sample_nxt;
      res_voice_active <= (env_stage_r != ST_IDLE);
      res_stage        <= env_stage_r;
    end
  end

endmodule

FILE: hdl/adsr_wavetable_voice.sv
// ----------------------------------------------------------------------------
// adsr_wavetable_voice
// One fixed-point synthesizer voice: oscillator, ADSR envelope and gain.
// ----------------------------------------------------------------------------
// Input stream: in_tuser selects the kind of transaction, 0 a sample tick and
// 1 a note_on that loads phase step, waveform and duration from in_tdata.
// A note_on yields no result. Each tick yields one result
// on the output stream: signed sample, voice_active flag and envelope stage.
// A tick on a sounding voice runs the wave and envelope step, the two
// multiplies, the divide and its correction in turn on one datapath, and no
// new transaction is taken until its result is loaded. A tick on a silent
// voice skips to the output load and yields a zero sample.
// Configuration writes (cfg_we, cfg_addr, cfg_wdata) take effect at the next
// edge and must be issued while the voice is not busy; unknown indexes are
// dropped. Reset (rst_n low, synchronous) silences the voice, reseeds the
// noise generator and restores the register defaults.
// A finished result waits in the output register while out_tready is low;
// the next transaction is still taken, and its result holds until that slot
// frees up.
// ----------------------------------------------------------------------------
module adsr_wavetable_voice (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  // phase_step[23:0], waveform[26:24], duration_ticks[46:27], zero[47]
  input  logic [avw_pkg::IN_TDATA_W-1:0]     in_tdata,
  // command
  input  logic                               in_tuser,
  input  logic                               cfg_we,
  input  logic [avw_pkg::CFG_IDX_W-1:0]      cfg_addr,
  input  logic [avw_pkg::CFG_W-1:0]          cfg_wdata,
  output logic                               out_tvalid,
  input  logic                               out_tready,
  // sample[15:0], voice_active[16], envelope_stage[19:17], zero[23:20]
  output logic [avw_pkg::OUT_TDATA_W-1:0]    out_tdata
);
  import avw_pkg::*;

  avw_cmd_t                   cmd;
  avw_status_t                status;
  logic signed [SAMPLE_W-1:0] res_sample;
  logic                       res_voice_active;
  logic [STAGE_W-1:0]         res_stage;

  avw_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_is_note (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .status     (status),
    .cmd        (cmd)
  );

  avw_datapath u_datapath (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_addr         (cfg_addr),
    .cfg_wdata        (cfg_wdata),
    .note_phase_step  (in_tdata[23:0]),
    .note_waveform    (in_tdata[26:24]),
    .note_duration    (in_tdata[46:27]),
    .cmd              (cmd),
    .status           (status),
    .res_sample       (res_sample),
    .res_voice_active (res_voice_active),
    .res_stage        (res_stage)
  );

  assign out_tdata = {4'b0000, res_stage, res_voice_active, res_sample};

  a_silent_is_zero : assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tdata[16] |-> out_tdata[15:0] == 16'h0000 &&
                                     out_tdata[19:17] == ST_IDLE)
    else $error("silent voice result carries nonzero sample or stage");

  a_active_matches_stage : assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[16] == (out_tdata[19:17] != ST_IDLE))
    else $error("voice_active disagrees with envelope stage");

  a_note_starts_voice : assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && in_tuser |=> status.active)
    else $error("note_on did not start the voice");

endmodule
